FILE: hw/rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Widths, limits and register indexes for the filtered period averager.
// ----------------------------------------------------------------------------
package fpa_pkg;

	localparam int SAMPLE_W    = 32;
	localparam int MAX_SAMPLES = 16;
	// sum holds MAX_SAMPLES full-scale samples without wrapping
	localparam int SUM_W       = SAMPLE_W + $clog2(MAX_SAMPLES);
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
	localparam int BIT_W       = $clog2(SUM_W + 1);
	localparam int IDX_W       = $clog2(SAMPLE_W);
	localparam int REG_IDX_W   = 2;
	localparam int REG_DATA_W  = 32;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_FILTER_ENABLE = 2'd0;
	localparam reg_idx_t REG_WINDOW_MIN    = 2'd1;
	localparam reg_idx_t REG_WINDOW_MAX    = 2'd2;

endpackage

FILE: hw/rtl/filtered_period_averager_unit.sv
// ----------------------------------------------------------------------------
// filtered_period_averager_unit
// Averages period samples over one control period, optionally keeping only
// samples inside a window, and emits the mean on the closing item.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  sample    in         sample_valid/sample_stall  period_sample, has_sample,
//                                                  end_of_period
//  result    out        result_valid/result_stall  mean_period, used_samples,
//                                                  overflowed
//  config    in         write_enable               reg_index, write_data
//
//  A stored sample is accepted in IDLE, then window compare and sum add run
//  bit-serially in ADD, one bit per cycle, through the sample and sum shift registers.
//  A closing item adds a restoring division in DIV, one quotient bit per
//  cycle, then DONE loads the result register once the result slot is free.
//  Dropped samples and items with neither a sample nor a close skip ADD.
//  Reset clears the period state and sets the registers to their defaults.
//  A waiting result does not block new samples; only the next mean waits for it, and samples stall while it waits.
// ----------------------------------------------------------------------------
module filtered_period_averager_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic [fpa_pkg::SAMPLE_W-1:0]  period_sample,
	input  logic                          has_sample,
	input  logic                          end_of_period,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [fpa_pkg::SAMPLE_W-1:0]  mean_period,
	output logic [fpa_pkg::CNT_W-1:0]     used_samples,
	output logic                          overflowed,
	input  logic                          write_enable,
	input  fpa_pkg::reg_idx_t             reg_index,
	input  logic [fpa_pkg::REG_DATA_W-1:0] write_data
);
	import fpa_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ADD  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]          state_q;
	logic                filter_en_q;
	logic [SAMPLE_W-1:0] window_min_q;
	logic [SAMPLE_W-1:0] window_max_q;

	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    acc_q;
	logic [CNT_W-1:0]    seen_q;
	logic                ovf_q;
	logic                last_q;
	logic [BIT_W-1:0]    bit_cnt_q;

	logic [SAMPLE_W-1:0] samp_q;
	logic [SUM_W-1:0]    cand_q;
	logic                carry_q;
	logic                ge_q;
	logic                le_q;
	logic [CNT_W-1:0]    rem_q;

	logic                res_valid_q;
	logic [SAMPLE_W-1:0] res_mean_q;
	logic [CNT_W-1:0]    res_used_q;
	logic                res_ovf_q;

	logic                in_fire;
	logic                room;
	logic                bit_last;
	logic                cmp_phase;
	logic                s_bit;
	logic                min_bit;
	logic                max_bit;
	logic                sum_bit;
	logic                carry_next;
	logic                ge_next;
	logic                le_next;
	logic                take;
	logic [SUM_W-1:0]    cand_next;
	logic [CNT_W:0]      trial;
	logic                q_bit;
	logic [CNT_W:0]      trial_sub;
	logic                res_free;
	logic                res_load;

	assign sample_stall = (state_q != ST_IDLE);
	assign in_fire      = sample_valid && !sample_stall;
	assign room         = (seen_q < CNT_W'(MAX_SAMPLES));
	assign bit_last     = (bit_cnt_q == BIT_W'(SUM_W - 1));
	assign cmp_phase    = (bit_cnt_q < BIT_W'(SAMPLE_W));

	// bit-serial compare and add, LSB first
	assign s_bit      = samp_q[0];
	assign min_bit    = window_min_q[bit_cnt_q[IDX_W-1:0]];
	assign max_bit    = window_max_q[bit_cnt_q[IDX_W-1:0]];
	assign sum_bit    = s_bit ^ sum_q[0] ^ carry_q;
	assign carry_next = (s_bit & sum_q[0]) | (carry_q & (s_bit ^ sum_q[0]));
	assign ge_next    = (s_bit & ~min_bit) | (~(s_bit ^ min_bit) & ge_q);
	assign le_next    = (~s_bit & max_bit) | (~(s_bit ^ max_bit) & le_q);
	assign cand_next  = {sum_bit, cand_q[SUM_W-1:1]};
	assign take       = !filter_en_q || (ge_q && le_q);

	// restoring division step, dividend enters MSB first from sum_q
	assign trial     = {rem_q, sum_q[SUM_W-1]};
	assign q_bit     = (trial >= {1'b0, acc_q});
	assign trial_sub = trial - {1'b0, acc_q};

	assign res_free = !res_valid_q || !result_stall;
	assign res_load = (state_q == ST_DONE) && res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_en_q  <= 1'b0;
			window_min_q <= '0;
			window_max_q <= '1;
		end else if (write_enable) begin
			unique case (reg_index)
				REG_FILTER_ENABLE: filter_en_q  <= write_data[0];
				REG_WINDOW_MIN:    window_min_q <= write_data[SAMPLE_W-1:0];
				REG_WINDOW_MAX:    window_max_q <= write_data[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			sum_q     <= '0;
			acc_q     <= '0;
			seen_q    <= '0;
			ovf_q     <= 1'b0;
			last_q    <= 1'b0;
			bit_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						last_q    <= end_of_period;
						bit_cnt_q <= '0;
						if (has_sample && room) begin
							state_q <= ST_ADD;
						end else begin
							if (has_sample) begin
								ovf_q <= 1'b1;
							end
							if (end_of_period) begin
								state_q <= ST_DIV;
							end
						end
					end
				end
				ST_ADD: begin
					if (bit_last) begin
						seen_q    <= seen_q + CNT_W'(1);
						bit_cnt_q <= '0;
						if (take) begin
							sum_q <= cand_next;
							acc_q <= acc_q + CNT_W'(1);
						end else begin
							sum_q <= {sum_q[0], sum_q[SUM_W-1:1]};
						end
						state_q <= last_q ? ST_DIV : ST_IDLE;
					end else begin
						bit_cnt_q <= bit_cnt_q + BIT_W'(1);
						// rotate: a full pass restores the sum
						sum_q <= {sum_q[0], sum_q[SUM_W-1:1]};
					end
				end
				ST_DIV: begin
					bit_cnt_q <= bit_cnt_q + BIT_W'(1);
					sum_q     <= {sum_q[SUM_W-2:0], q_bit};
					if (bit_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_free) begin
						sum_q   <= '0;
						acc_q   <= '0;
						seen_q  <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath shift registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			samp_q  <= period_sample;
			carry_q <= 1'b0;
			ge_q    <= 1'b1;
			le_q    <= 1'b1;
			rem_q   <= '0;
		end else if (state_q == ST_ADD) begin
			samp_q  <= {1'b0, samp_q[SAMPLE_W-1:1]};
			cand_q  <= cand_next;
			carry_q <= carry_next;
			if (cmp_phase) begin
				ge_q <= ge_next;
				le_q <= le_next;
			end
			if (bit_last) begin
				rem_q <= '0;
			end
		end else if (state_q == ST_DIV) begin
			rem_q <= q_bit ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			// empty period divides by zero: report a zero mean
			res_mean_q <= (acc_q == '0) ? '0 : sum_q[SAMPLE_W-1:0];
			res_used_q <= acc_q;
			res_ovf_q  <= ovf_q;
		end
	end

	assign result_valid = res_valid_q;
	assign mean_period  = res_mean_q;
	assign used_samples = res_used_q;
	assign overflowed   = res_ovf_q;

`ifndef NO_ASSERTIONS
	a_acc_le_seen: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q <= seen_q)
		else $error("accepted count above stored count");

	a_seen_cap: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= CNT_W'(MAX_SAMPLES))
		else $error("stored count above capacity");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && acc_q != '0) |-> (rem_q < acc_q))
		else $error("division remainder out of range");

	a_period_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> (state_q == ST_IDLE && seen_q == '0 && acc_q == '0
			&& !ovf_q && sum_q == '0 && result_valid))
		else $error("period state not cleared after result");

	a_drop_no_work: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && has_sample && !room) |=> (seen_q == $past(seen_q) && ovf_q))
		else $error("dropped sample changed the count");
`endif

endmodule

FILE: dv/filtered_period_averager_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// filtered_period_averager_unit_tb
// Sends control periods of samples through the averager, mostly under random
// valid/stall gaps. A scoreboard predicts each period's mean, used count and
// overflow flag, and compares them field by field with every result taken.
// ----------------------------------------------------------------------------
module filtered_period_averager_unit_tb;
	import fpa_pkg::*;

	localparam int       SETTLE_CYCLES = 100;   // > one stored sample plus a full divide
	localparam int       STALL_LIMIT   = 4000;  // cycles with no item moving on either side
	localparam int       RANDOM_ITEMS  = 700;
	localparam reg_idx_t REG_UNUSED    = 2'd3;  // no register here, write is dropped

	typedef struct packed {
		logic [SAMPLE_W-1:0] mean;
		logic [CNT_W-1:0]    used;
		logic                ovf;
	} period_mean_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  sample_valid;
	logic                  sample_stall;
	logic [SAMPLE_W-1:0]   period_sample;
	logic                  has_sample;
	logic                  end_of_period;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic [SAMPLE_W-1:0]   mean_period;
	logic [CNT_W-1:0]      used_samples;
	logic                  overflowed;
	logic                  write_enable;
	reg_idx_t              reg_index;
	logic [REG_DATA_W-1:0] write_data;

	// scoreboard copy of registers and period state
	logic                  cfg_filter;
	logic [SAMPLE_W-1:0]   cfg_min;
	logic [SAMPLE_W-1:0]   cfg_max;
	logic [SUM_W-1:0]      period_sum;
	logic [CNT_W-1:0]      period_used;
	logic [CNT_W-1:0]      period_seen;
	logic                  period_ovf;

	period_mean_t          pending_means[$];
	int                    mismatch_count = 0;
	int                    sample_items   = 0;
	int                    quiet_cycles   = 0;
	bit                    gaps_on        = 1'b1;

	filtered_period_averager_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.period_sample (period_sample),
		.has_sample    (has_sample),
		.end_of_period (end_of_period),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.mean_period   (mean_period),
		.used_samples  (used_samples),
		.overflowed    (overflowed),
		.write_enable  (write_enable),
		.reg_index     (reg_index),
		.write_data    (write_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// scoreboard update for one accepted item
	task automatic predict_period_mean(input logic [SAMPLE_W-1:0] smp, input logic with_smp,
			input logic closing);
		period_mean_t res;
		if (with_smp) begin
			if (period_seen < CNT_W'(MAX_SAMPLES)) begin
				period_seen++;
				if (!cfg_filter || (smp >= cfg_min && smp <= cfg_max)) begin
					period_sum  = period_sum + SUM_W'(smp);
					period_used = period_used + 1'b1;
				end
			end else begin
				period_ovf = 1'b1;
			end
		end
		if (closing) begin
			res.mean = (period_used == '0) ? '0 :
				SAMPLE_W'(period_sum / SUM_W'(period_used));
			res.used = period_used;
			res.ovf  = period_ovf;
			pending_means.push_back(res);
			period_sum  = '0;
			period_used = '0;
			period_seen = '0;
			period_ovf  = 1'b0;
		end
	endtask

	task automatic send_item(input logic [SAMPLE_W-1:0] smp, input logic with_smp,
			input logic closing);
		if (gaps_on) begin
			while ($urandom_range(0, 99) < 25) begin
				sample_valid <= 1'b0;
				@(posedge clk);
			end
		end
		sample_valid  <= 1'b1;
		period_sample <= smp;
		has_sample    <= with_smp;
		end_of_period <= closing;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		predict_period_mean(smp, with_smp, closing);
		if (with_smp || closing)
			sample_items++;
	endtask

	// stop sending, let every mean come out, then let the datapath settle
	task automatic quiesce(input int settle);
		sample_valid <= 1'b0;
		while (pending_means.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [REG_DATA_W-1:0] data);
		write_enable <= 1'b1;
		reg_index    <= idx;
		write_data   <= data;
		@(posedge clk);
		write_enable <= 1'b0;
		case (idx)
			REG_FILTER_ENABLE: cfg_filter = data[0];
			REG_WINDOW_MIN:    cfg_min    = data;
			REG_WINDOW_MAX:    cfg_max    = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_window(input logic en, input logic [SAMPLE_W-1:0] lo,
			input logic [SAMPLE_W-1:0] hi);
		quiesce(SETTLE_CYCLES);
		write_reg(REG_FILTER_ENABLE, ($urandom() & ~32'h1) | REG_DATA_W'(en));
		write_reg(REG_WINDOW_MIN, lo);
		write_reg(REG_WINDOW_MAX, hi);
	endtask

	// biased toward window edges and full-scale values
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return cfg_min;
			3: return cfg_max;
			4: return cfg_min - 1'b1;
			5: return cfg_max + 1'b1;
			6, 7: begin
				if (cfg_min <= cfg_max)
					return $urandom_range(cfg_max, cfg_min);
				return $urandom();
			end
			default: return $urandom();
		endcase
	endfunction

	task automatic test_defaults();
		send_item(32'h0, 1'b1, 1'b0);
		send_item(32'hFFFF_FFFF, 1'b1, 1'b1);
		send_item($urandom(), 1'b0, 1'b0);   // neither sample nor close: ignored
		send_item($urandom(), 1'b0, 1'b1);   // nothing counted, mean 0
	endtask

	task automatic test_capacity();
		repeat (MAX_SAMPLES) send_item(32'hFFFF_FFFF, 1'b1, 1'b0);
		send_item(32'h1, 1'b1, 1'b1);        // dropped, sets overflow
		send_item(32'h3, 1'b1, 1'b1);        // next period starts clean
	endtask

	task automatic test_registers();
		quiesce(SETTLE_CYCLES);
		write_reg(REG_WINDOW_MIN, 32'd100);
		write_reg(REG_WINDOW_MAX, 32'd200);
		write_reg(REG_FILTER_ENABLE, 32'hFFFF_FFFE);  // only bit 0 counts
		send_item(32'd1000, 1'b1, 1'b1);
		quiesce(SETTLE_CYCLES);
		write_reg(REG_UNUSED, $urandom());
		write_reg(REG_FILTER_ENABLE, 32'h1);
		send_item(32'd99, 1'b1, 1'b0);
		send_item(32'd100, 1'b1, 1'b0);
		send_item(32'd200, 1'b1, 1'b0);
		send_item(32'd201, 1'b1, 1'b0);
		send_item($urandom(), 1'b0, 1'b1);
		set_window(1'b1, 32'd10, 32'd5);              // empty window
		send_item(32'd7, 1'b1, 1'b1);
	endtask

	task automatic run_periods(input int n_items, input bit pause_midway);
		int stop_at;
		int len;
		stop_at = sample_items + n_items;
		while (sample_items < stop_at) begin
			len = ($urandom_range(0, 99) < 15) ? $urandom_range(14, 20) : $urandom_range(0, 6);
			repeat (len) begin
				if ($urandom_range(0, 99) < 10)
					send_item($urandom(), 1'b0, 1'b0);
				send_item(pick_sample(), 1'b1, 1'b0);
			end
			send_item(pick_sample(), $urandom_range(0, 1), 1'b1);
			if (pause_midway && sample_items >= stop_at - n_items / 2) begin
				quiesce(0);
				pause_midway = 1'b0;
			end
		end
	endtask

	task automatic test_random();
		int per_phase;
		logic [SAMPLE_W-1:0] a;
		logic [SAMPLE_W-1:0] b;
		per_phase = RANDOM_ITEMS / 8;
		for (int phase = 0; phase < 8; phase++) begin
			a = $urandom();
			b = $urandom();
			if (a > b) begin
				a ^= b;
				b ^= a;
				a ^= b;
			end
			case (phase)
				0: set_window(1'b0, $urandom(), $urandom());
				1: set_window(1'b1, 32'h0, 32'hFFFF_FFFF);
				2: set_window(1'b1, a, b);
				3: set_window(1'b1, a, a);
				4: set_window(1'b1, b, a);
				5: set_window(1'b1, 32'h0, b);
				6: set_window(1'b1, a, 32'hFFFF_FFFF);
				default: set_window(1'b1, a, b);
			endcase
			gaps_on = (phase != 6);
			run_periods(per_phase, phase == 2);
		end
		gaps_on = 1'b1;
	endtask

	always @(posedge clk) begin : check_results
		period_mean_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_means.size() == 0) begin
				$error("result with nothing expected: mean_period %0d", mean_period);
				mismatch_count++;
			end else begin
				want = pending_means.pop_front();
				if (mean_period !== want.mean) begin
					$error("mean_period expected %0d actual %0d", want.mean, mean_period);
					mismatch_count++;
				end
				if (used_samples !== want.used) begin
					$error("used_samples expected %0d actual %0d", want.used, used_samples);
					mismatch_count++;
				end
				if (overflowed !== want.ovf) begin
					$error("overflowed expected %0b actual %0b", want.ovf, overflowed);
					mismatch_count++;
				end
			end
		end
		result_stall <= gaps_on && ($urandom_range(0, 99) < 25);
	end

	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		arst_n        <= 1'b0;
		sample_valid  <= 1'b0;
		period_sample <= '0;
		has_sample    <= 1'b0;
		end_of_period <= 1'b0;
		write_enable  <= 1'b0;
		reg_index     <= REG_FILTER_ENABLE;
		write_data    <= '0;
		cfg_filter  = 1'b0;
		cfg_min     = '0;
		cfg_max     = '1;
		period_sum  = '0;
		period_used = '0;
		period_seen = '0;
		period_ovf  = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults();
		test_capacity();
		test_registers();
		test_random();

		quiesce(SETTLE_CYCLES);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/fpa_pkg.sv
hw/rtl/filtered_period_averager_unit.sv
dv/filtered_period_averager_unit_tb.sv
